// ===== sv/assert_macros.svh =====
// Assertion helpers; they expect clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QA_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/qalu_pkg.sv =====
package qalu_pkg;

  typedef logic signed [31:0] comp_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_CONJ = 2'd1,
    OP_ROT  = 2'd2
  } op_t;

  localparam comp_t COMP_MAX = comp_t'(32'h7FFF_FFFF);
  localparam comp_t COMP_MIN = comp_t'(32'h8000_0000);

  // product row/term layout: term k of a row multiplies b[k] by a[QIDX[row][k]]
  localparam logic [1:0] QIDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // bit k set: term k of the row is subtracted
  localparam logic [3:0] NSGN [4] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};

endpackage

// ===== sv/qalu_ifs.sv =====
interface qalu_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  qalu_pkg::comp_t   q_w;
  qalu_pkg::comp_t   q_x;
  qalu_pkg::comp_t   q_y;
  qalu_pkg::comp_t   q_z;
  qalu_pkg::comp_t   r_w;
  qalu_pkg::comp_t   r_x;
  qalu_pkg::comp_t   r_y;
  qalu_pkg::comp_t   r_z;

  modport source (output valid, op, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z,
                  input ready);
  modport sink   (input valid, op, q_w, q_x, q_y, q_z, r_w, r_x, r_y, r_z,
                  output ready);
endinterface

interface qalu_out_if;
  logic              valid;
  logic              ready;
  qalu_pkg::comp_t   p_w;
  qalu_pkg::comp_t   p_x;
  qalu_pkg::comp_t   p_y;
  qalu_pkg::comp_t   p_z;
  logic              saturated;

  modport source (output valid, p_w, p_x, p_y, p_z, saturated, input ready);
  modport sink   (input valid, p_w, p_x, p_y, p_z, saturated, output ready);
endinterface

// ===== sv/quaternion_alu.sv =====
// Fixed-point quaternion unit: multiply, conjugate, rotate a vector by q.
// in_if carries one request (op plus operands q and r); out_if returns one
// result quaternion and a saturation flag per request, in request order.
// Components are signed 32-bit with FRAC_BITS fraction bits; each sum of four
// products is floored by the fraction shift and clipped to 32 bits.
// Pipeline: input register, the first bank of sixteen multipliers in product,
// sum and round/clip stages, the second bank in product and sum stages, then
// the output register, which takes the second round/clip and the op select.
// A request is registered in each of these stages in turn before its result is
// valid on out_if; one request per cycle is taken sustained while out_if is ready,
// set by the fully pipelined multiply banks.
// Every stage carries its own valid bit and loads whenever it is empty or the
// stage behind it moves, so a stall on out_if backs up stage by stage, empty
// slots fill in, and in_if.ready drops only once all seven stages are full.
// Reset (rst_n low at a clock edge) empties the pipeline; results in flight
// are dropped. Op code three returns zeros with the flag clear.
module quaternion_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  qalu_in_if.sink     in_if,
  qalu_out_if.source  out_if
);

  localparam int SUM1_W = 67;  // four 32x33 products
  localparam int SUM2_W = 66;  // four 32x32 products

  typedef struct packed {
    logic            flag;
    qalu_pkg::comp_t val;
  } sat_t;

  function automatic sat_t clip(input logic signed [SUM1_W-1:0] v);
    sat_t                 res;
    logic [SUM1_W-32:0]   hi;
    hi = v[SUM1_W-1:31];
    if (&hi || ~|hi) begin
      res.flag = 1'b0;
      res.val  = qalu_pkg::comp_t'(v[31:0]);
    end else begin
      res.flag = 1'b1;
      res.val  = v[SUM1_W-1] ? qalu_pkg::COMP_MIN : qalu_pkg::COMP_MAX;
    end
    return res;
  endfunction

  // pipeline control
  logic [6:0] v_r;
  logic [7:0] en;

  always_comb begin
    en[7] = out_if.ready;
    for (int k = 6; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_if.valid;
      for (int k = 1; k < 7; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // payload
  logic [1:0]              op_r     [7];
  qalu_pkg::comp_t         q_r      [6][4];
  qalu_pkg::comp_t         a0_r     [4];
  logic signed [32:0]      b0_r     [4];
  logic signed [64:0]      prod1_r  [4][4];
  logic signed [SUM1_W-1:0] sum1_r  [4];
  qalu_pkg::comp_t         t_r      [3:5][4];
  logic                    sat1_r   [3:5];
  logic signed [63:0]      prod2_r  [4][4];
  logic signed [SUM2_W-1:0] sum2_r  [4];
  qalu_pkg::comp_t         p_r      [4];
  logic                    sat_r;

  // stage 0: pick the first bank's operands
  qalu_pkg::comp_t    a_nxt [4];
  logic signed [32:0] b_nxt [4];

  always_comb begin
    if (in_if.op == qalu_pkg::OP_ROT) begin
      // vector times conjugate of q; the 33-bit negation is exact
      a_nxt[0] = '0;
      a_nxt[1] = in_if.r_x;
      a_nxt[2] = in_if.r_y;
      a_nxt[3] = in_if.r_z;
      b_nxt[0] = 33'(in_if.q_w);
      b_nxt[1] = -33'(in_if.q_x);
      b_nxt[2] = -33'(in_if.q_y);
      b_nxt[3] = -33'(in_if.q_z);
    end else begin
      a_nxt[0] = in_if.q_w;
      a_nxt[1] = in_if.q_x;
      a_nxt[2] = in_if.q_y;
      a_nxt[3] = in_if.q_z;
      b_nxt[0] = 33'(in_if.r_w);
      b_nxt[1] = 33'(in_if.r_x);
      b_nxt[2] = 33'(in_if.r_y);
      b_nxt[3] = 33'(in_if.r_z);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op_r[0]    <= in_if.op;
      q_r[0][0]  <= in_if.q_w;
      q_r[0][1]  <= in_if.q_x;
      q_r[0][2]  <= in_if.q_y;
      q_r[0][3]  <= in_if.q_z;
      a0_r       <= a_nxt;
      b0_r       <= b_nxt;
    end
  end

  // stage 1: first bank products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      op_r[1] <= op_r[0];
      q_r[1]  <= q_r[0];
      for (int row = 0; row < 4; row++) begin
        for (int k = 0; k < 4; k++) begin
          prod1_r[row][k] <= b0_r[k] * a0_r[qalu_pkg::QIDX[row][k]];
        end
      end
    end
  end

  // stage 2: signed sums at full precision
  logic signed [SUM1_W-1:0] sum1_nxt [4];

  always_comb begin
    for (int row = 0; row < 4; row++) begin
      sum1_nxt[row] = '0;
      for (int k = 0; k < 4; k++) begin
        if (qalu_pkg::NSGN[row][k]) sum1_nxt[row] = sum1_nxt[row] - SUM1_W'(prod1_r[row][k]);
        else                        sum1_nxt[row] = sum1_nxt[row] + SUM1_W'(prod1_r[row][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      op_r[2] <= op_r[1];
      q_r[2]  <= q_r[1];
      sum1_r  <= sum1_nxt;
    end
  end

  // stage 3: floor shift and clip the first product
  sat_t            clip1 [4];
  qalu_pkg::comp_t t_nxt [4];
  logic            sat1_nxt;

  always_comb begin
    sat1_nxt = 1'b0;
    for (int row = 0; row < 4; row++) begin
      clip1[row] = clip(SUM1_W'($signed(sum1_r[row][SUM1_W-1:FRAC_BITS])));
      t_nxt[row] = clip1[row].val;
      sat1_nxt   = sat1_nxt | clip1[row].flag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      op_r[3]   <= op_r[2];
      q_r[3]    <= q_r[2];
      t_r[3]    <= t_nxt;
      sat1_r[3] <= sat1_nxt;
    end
  end

  // stage 4: second bank products, q times t
  always_ff @(posedge clk) begin
    if (en[4]) begin
      op_r[4]   <= op_r[3];
      q_r[4]    <= q_r[3];
      t_r[4]    <= t_r[3];
      sat1_r[4] <= sat1_r[3];
      for (int row = 0; row < 4; row++) begin
        for (int k = 0; k < 4; k++) begin
          prod2_r[row][k] <= t_r[3][k] * q_r[3][qalu_pkg::QIDX[row][k]];
        end
      end
    end
  end

  // stage 5: second bank sums
  logic signed [SUM2_W-1:0] sum2_nxt [4];

  always_comb begin
    for (int row = 0; row < 4; row++) begin
      sum2_nxt[row] = '0;
      for (int k = 0; k < 4; k++) begin
        if (qalu_pkg::NSGN[row][k]) sum2_nxt[row] = sum2_nxt[row] - SUM2_W'(prod2_r[row][k]);
        else                        sum2_nxt[row] = sum2_nxt[row] + SUM2_W'(prod2_r[row][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      op_r[5]   <= op_r[4];
      q_r[5]    <= q_r[4];
      t_r[5]    <= t_r[4];
      sat1_r[5] <= sat1_r[4];
      sum2_r    <= sum2_nxt;
    end
  end

  // stage 6: clip the second product and select the result
  sat_t            clip2 [4];
  sat_t            neg   [1:3];
  qalu_pkg::comp_t p_nxt [4];
  logic            sat_nxt;
  logic            sat2_any;

  always_comb begin
    sat2_any = 1'b0;
    for (int row = 0; row < 4; row++) begin
      clip2[row] = clip(SUM1_W'($signed(sum2_r[row][SUM2_W-1:FRAC_BITS])));
      sat2_any   = sat2_any | clip2[row].flag;
    end
    for (int i = 1; i < 4; i++) begin
      if (q_r[5][i] == qalu_pkg::COMP_MIN) begin
        neg[i].flag = 1'b1;
        neg[i].val  = qalu_pkg::COMP_MAX;
      end else begin
        neg[i].flag = 1'b0;
        neg[i].val  = -q_r[5][i];
      end
    end
    unique case (op_r[5])
      qalu_pkg::OP_MUL: begin
        p_nxt   = t_r[5];
        sat_nxt = sat1_r[5];
      end
      qalu_pkg::OP_CONJ: begin
        p_nxt[0] = q_r[5][0];
        p_nxt[1] = neg[1].val;
        p_nxt[2] = neg[2].val;
        p_nxt[3] = neg[3].val;
        sat_nxt  = neg[1].flag | neg[2].flag | neg[3].flag;
      end
      qalu_pkg::OP_ROT: begin
        // scalar part dropped, but its clipping still counts
        p_nxt[0] = '0;
        p_nxt[1] = clip2[1].val;
        p_nxt[2] = clip2[2].val;
        p_nxt[3] = clip2[3].val;
        sat_nxt  = sat1_r[5] | sat2_any;
      end
      default: begin
        p_nxt   = '{default: '0};
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      op_r[6] <= op_r[5];
      p_r     <= p_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_if.valid     = v_r[6];
  assign out_if.p_w       = p_r[0];
  assign out_if.p_x       = p_r[1];
  assign out_if.p_y       = p_r[2];
  assign out_if.p_z       = p_r[3];
  assign out_if.saturated = sat_r;

  // a clipped product leaves at least one component on a rail
  logic rail_hit;

  always_comb begin
    rail_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rail_hit = rail_hit || p_r[i] == qalu_pkg::COMP_MAX || p_r[i] == qalu_pkg::COMP_MIN;
    end
  end

  `include "assert_macros.svh"

  `QA_NEXT(a_mid_hold, v_r[3] && !en[3],
           v_r[3] && $stable(t_r[3][1]) && $stable(sat1_r[3]),
           "stage 3 lost its item while stalled")
  `QA_NEXT(a_out_fill, v_r[5] && en[6], v_r[6], "item dropped entering output stage")
  `QA_IMPLIES(a_rot_scalar, v_r[6] && op_r[6] == qalu_pkg::OP_ROT, p_r[0] == '0,
              "rotate scalar not zero")
  `QA_IMPLIES(a_mul_rail, v_r[6] && op_r[6] == qalu_pkg::OP_MUL && sat_r, rail_hit,
              "flag set with no clipped component")

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = 16;
  localparam int IDLE_MAX     = 19;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam qalu_pkg::comp_t ONE = qalu_pkg::comp_t'(1 << FRAC_BITS);

  typedef qalu_pkg::comp_t quat_t [4];
  typedef longint wide_quat_t [4];

  typedef struct {
    logic [1:0] op;
    quat_t      q;
    quat_t      r;
  } quat_request_t;

  typedef struct {
    logic [1:0]      op;
    qalu_pkg::comp_t p_w;
    qalu_pkg::comp_t p_x;
    qalu_pkg::comp_t p_y;
    qalu_pkg::comp_t p_z;
    logic            sat;
  } quat_result_t;

  logic clk = 1'b0;
  logic rst_n;

  qalu_in_if  in_ch ();
  qalu_out_if out_ch ();

  quaternion_alu #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  quat_result_t pending_results[$];
  int mismatch_count  = 0;
  int in_idle_max     = IDLE_MAX;
  int out_idle_max    = IDLE_MAX;
  int hold_off_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor by the fraction shift, then clip to 32 bits
  function automatic qalu_pkg::comp_t round_clip(input logic signed [67:0] acc,
                                                 inout bit sat);
    logic signed [67:0] sh;
    sh = acc >>> FRAC_BITS;
    if (sh > 68'sd2147483647) begin
      sat = 1'b1;
      return qalu_pkg::COMP_MAX;
    end
    if (sh < -68'sd2147483648) begin
      sat = 1'b1;
      return qalu_pkg::COMP_MIN;
    end
    return qalu_pkg::comp_t'(sh[31:0]);
  endfunction

  // a * b in Hamilton order, each row summed at full width
  function automatic void hamilton(input wide_quat_t a, input wide_quat_t b,
                                   output quat_t p, inout bit sat);
    logic signed [67:0] acc [4];
    acc[0] = b[0]*a[0] - b[1]*a[1] - b[2]*a[2] - b[3]*a[3];
    acc[1] = b[0]*a[1] + b[1]*a[0] - b[2]*a[3] + b[3]*a[2];
    acc[2] = b[0]*a[2] + b[1]*a[3] + b[2]*a[0] - b[3]*a[1];
    acc[3] = b[0]*a[3] - b[1]*a[2] + b[2]*a[1] + b[3]*a[0];
    for (int i = 0; i < 4; i++)
      p[i] = round_clip(acc[i], sat);
  endfunction

  function automatic quat_result_t predict_result(input quat_request_t req);
    quat_result_t res;
    wide_quat_t qa, ra, va, qc, ta;
    quat_t p, t;
    bit sat;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      p[i]  = '0;
      qa[i] = req.q[i];
      ra[i] = req.r[i];
    end
    case (req.op)
      qalu_pkg::OP_MUL: hamilton(qa, ra, p, sat);
      qalu_pkg::OP_CONJ: begin
        p[0] = req.q[0];
        for (int i = 1; i < 4; i++) begin
          if (req.q[i] == qalu_pkg::COMP_MIN) begin
            p[i] = qalu_pkg::COMP_MAX;
            sat  = 1'b1;
          end else begin
            p[i] = -req.q[i];
          end
        end
      end
      qalu_pkg::OP_ROT: begin
        // conjugate kept exact at 64 bits; the inner product is clipped
        va = '{0, ra[1], ra[2], ra[3]};
        qc = '{qa[0], -qa[1], -qa[2], -qa[3]};
        hamilton(va, qc, t, sat);
        for (int i = 0; i < 4; i++)
          ta[i] = t[i];
        hamilton(qa, ta, p, sat);
        p[0] = '0;
      end
      default: ;
    endcase
    res.op  = req.op;
    res.p_w = p[0];
    res.p_x = p[1];
    res.p_y = p[2];
    res.p_z = p[3];
    res.sat = sat;
    return res;
  endfunction

  function automatic quat_request_t make_request(input logic [1:0] op,
      input qalu_pkg::comp_t qw, input qalu_pkg::comp_t qx,
      input qalu_pkg::comp_t qy, input qalu_pkg::comp_t qz,
      input qalu_pkg::comp_t rw, input qalu_pkg::comp_t rx,
      input qalu_pkg::comp_t ry, input qalu_pkg::comp_t rz);
    quat_request_t req;
    req.op = op;
    req.q  = '{qw, qx, qy, qz};
    req.r  = '{rw, rx, ry, rz};
    return req;
  endfunction

  function automatic qalu_pkg::comp_t rand_bounded(input int mag);
    return qalu_pkg::comp_t'(int'($urandom_range(0, 2 * mag)) - mag);
  endfunction

  function automatic qalu_pkg::comp_t rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2:    return qalu_pkg::comp_t'($urandom);
      3, 4, 5, 6: return rand_bounded(1 << 18);
      7:          return rand_bounded(1 << 24);
      8:          return $urandom_range(0, 1) ? qalu_pkg::COMP_MAX : qalu_pkg::COMP_MIN;
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return qalu_pkg::comp_t'(1);
          2:       return qalu_pkg::comp_t'(-1);
          3:       return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic [1:0] rand_op();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7)
      return qalu_pkg::OP_MUL;
    if (pick < 13)
      return qalu_pkg::OP_CONJ;
    if (pick < 19)
      return qalu_pkg::OP_ROT;
    return OP_UNUSED;
  endfunction

  function automatic quat_request_t rand_request();
    quat_request_t req;
    req.op = rand_op();
    for (int i = 0; i < 4; i++) begin
      req.q[i] = rand_comp();
      req.r[i] = rand_comp();
    end
    return req;
  endfunction

  task automatic send_request(input quat_request_t req);
    int gap;
    gap = (in_idle_max > 0) ? $urandom_range(0, in_idle_max) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= req.op;
    in_ch.q_w   <= req.q[0];
    in_ch.q_x   <= req.q[1];
    in_ch.q_y   <= req.q[2];
    in_ch.q_z   <= req.q[3];
    in_ch.r_w   <= req.r[0];
    in_ch.r_x   <= req.r[1];
    in_ch.r_y   <= req.r[2];
    in_ch.r_z   <= req.r[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_result(req));
  endtask

  // drop valid and hold until the pipeline has drained
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    quat_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected result: w=%h x=%h y=%h z=%h sat=%b",
                 out_ch.p_w, out_ch.p_x, out_ch.p_y, out_ch.p_z, out_ch.saturated);
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.p_w !== want.p_w || out_ch.p_x !== want.p_x || out_ch.p_y !== want.p_y ||
        out_ch.p_z !== want.p_z || out_ch.saturated !== want.sat) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("mismatch op %0d: expected w=%h x=%h y=%h z=%h sat=%b",
                 want.op, want.p_w, want.p_x, want.p_y, want.p_z, want.sat);
        $display("                 actual   w=%h x=%h y=%h z=%h sat=%b",
                 out_ch.p_w, out_ch.p_x, out_ch.p_y, out_ch.p_z, out_ch.saturated);
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        n = (out_idle_max > 0) ? $urandom_range(0, out_idle_max) : 0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      check_result();
    end
  end

  // end the run if nothing moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_directed();
    qalu_pkg::comp_t c45;
    qalu_pkg::comp_t cmax;
    qalu_pkg::comp_t cmin;
    c45  = qalu_pkg::comp_t'(46341);
    cmax = qalu_pkg::COMP_MAX;
    cmin = qalu_pkg::COMP_MIN;
    // identities, basis products, zeros
    send_request(make_request(qalu_pkg::OP_MUL, ONE, 0, 0, 0, ONE, 0, 0, 0));
    send_request(make_request(qalu_pkg::OP_MUL, 0, ONE, 0, 0, 0, 0, ONE, 0));
    send_request(make_request(qalu_pkg::OP_MUL, 0, 0, ONE, 0, 0, 0, 0, ONE));
    send_request(make_request(qalu_pkg::OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0));
    // extremes and saturation
    send_request(make_request(qalu_pkg::OP_MUL, cmax, cmax, cmax, cmax,
                              cmax, cmax, cmax, cmax));
    send_request(make_request(qalu_pkg::OP_MUL, cmin, cmin, cmin, cmin,
                              cmin, cmin, cmin, cmin));
    send_request(make_request(qalu_pkg::OP_MUL, cmax, cmin, cmax, cmin,
                              cmin, cmax, cmin, cmax));
    // floor rounding of tiny values
    send_request(make_request(qalu_pkg::OP_MUL, -1, -1, -1, -1, -1, -1, -1, -1));
    send_request(make_request(qalu_pkg::OP_MUL, 1, 1, 1, 1, -1, 1, -1, 1));
    // right at the clip boundary, one step inside, and the exact minimum
    send_request(make_request(qalu_pkg::OP_MUL, 1 << 24, 0, 0, 0, 1 << 23, 0, 0, 0));
    send_request(make_request(qalu_pkg::OP_MUL, 1 << 24, 0, 0, 0, (1 << 23) - 1, 0, 0, 0));
    send_request(make_request(qalu_pkg::OP_MUL, -(1 << 24), 0, 0, 0, 1 << 23, 0, 0, 0));
    // conjugate, including negation of the most negative value
    send_request(make_request(qalu_pkg::OP_CONJ, ONE, ONE, -ONE, 7, 0, 0, 0, 0));
    send_request(make_request(qalu_pkg::OP_CONJ, cmin, cmin, cmin, cmin,
                              cmax, cmax, cmax, cmax));
    send_request(make_request(qalu_pkg::OP_CONJ, cmax, cmax, cmax, cmax, 0, 0, 0, 0));
    send_request(make_request(qalu_pkg::OP_CONJ, cmin, 0, 0, cmin, 0, 0, 0, 0));
    // rotate: identity, quarter turn about z, extremes, ignored scalar
    send_request(make_request(qalu_pkg::OP_ROT, ONE, 0, 0, 0, 0, ONE, 2 * ONE, 3 * ONE));
    send_request(make_request(qalu_pkg::OP_ROT, c45, 0, 0, c45, 0, ONE, 0, 0));
    send_request(make_request(qalu_pkg::OP_ROT, cmin, cmin, cmin, cmin,
                              cmin, cmin, cmin, cmin));
    send_request(make_request(qalu_pkg::OP_ROT, cmax, cmax, cmax, cmax,
                              cmax, cmax, cmax, cmax));
    send_request(make_request(qalu_pkg::OP_ROT, 0, cmin, 0, 0, 0, 1, 0, 0));
    send_request(make_request(qalu_pkg::OP_ROT, c45, c45, 0, 0, cmax, 0, ONE, -ONE));
    // unused op code returns zeros
    send_request(make_request(OP_UNUSED, cmax, cmax, cmax, cmax,
                              cmin, cmin, cmin, cmin));
    send_request(make_request(OP_UNUSED, ONE, -ONE, 5, -5, ONE, ONE, ONE, ONE));
  endtask

  task automatic test_random_mixed(input int count);
    in_idle_max  = IDLE_MAX;
    out_idle_max = IDLE_MAX;
    repeat (count) send_request(rand_request());
  endtask

  task automatic test_streaming(input int count);
    in_idle_max  = 0;
    out_idle_max = 0;
    repeat (count) send_request(rand_request());
    in_idle_max  = IDLE_MAX;
    out_idle_max = IDLE_MAX;
  endtask

  task automatic test_backpressure(input int count);
    wait_for_results();
    in_idle_max     = 0;
    hold_off_cycles = HOLD_CYCLES;
    repeat (count) send_request(rand_request());
    in_idle_max = IDLE_MAX;
    wait_for_results();
  endtask

  // unit-scale rotations and products that stay clear of saturation
  task automatic test_realistic(input int count);
    quat_request_t req;
    repeat (count) begin
      req.op = $urandom_range(0, 2) == 0 ? qalu_pkg::OP_MUL : qalu_pkg::OP_ROT;
      for (int i = 0; i < 4; i++) begin
        req.q[i] = rand_bounded(ONE);
        req.r[i] = rand_bounded(16 * ONE);
      end
      send_request(req);
    end
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.op    <= qalu_pkg::OP_MUL;
    in_ch.q_w   <= '0;
    in_ch.q_x   <= '0;
    in_ch.q_y   <= '0;
    in_ch.q_z   <= '0;
    in_ch.r_w   <= '0;
    in_ch.r_x   <= '0;
    in_ch.r_y   <= '0;
    in_ch.r_z   <= '0;
    rst_n       <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mixed(300);
    test_streaming(200);
    test_backpressure(60);
    test_realistic(270);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
